// ----- hw/rtl/sle_pkg.sv -----
// Shared constants, operation codes and cell control type for the sorted list engine.
package sle_pkg;

  localparam int CAPACITY  = 64;
  localparam int DATA_W    = 32;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int OUT_CNT_W = 7;
  localparam int FUNC_W    = 3;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT     = 3'd0,
    FN_REMOVE_VAL = 3'd1,
    FN_REMOVE_MIN = 3'd2,
    FN_REMOVE_MAX = 3'd3,
    FN_CLEAR      = 3'd4
  } func_t;

  // Broadcast to every cell in the row for the item being applied.
  typedef struct packed {
    logic                     ins;    // insert, list not full
    logic                     rmv;    // remove first equal value, match found
    logic                     pop;    // remove smallest, list not empty
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// ----- hw/rtl/sle_cell.sv -----
// One slot of the sorted row: holds a value and shifts it toward either neighbor.
module sle_cell
  import sle_pkg::*;
(
  input  logic                     clk,
  input  cell_ctl_t                ctl,
  input  logic                     occ,       // slot lies below the count
  input  logic                     prev_lt,   // lower neighbor holds a value below ctl.value
  input  logic signed [DATA_W-1:0] prev_val,
  input  logic signed [DATA_W-1:0] next_val,
  output logic signed [DATA_W-1:0] val_r,
  output logic                     lt,
  output logic                     hit
);

  logic signed [DATA_W-1:0] val_nxt;

  assign lt  = occ && (val_r < ctl.value);
  // In an ascending row the first equal entry is the one whose lower neighbor is smaller.
  assign hit = occ && (val_r == ctl.value) && prev_lt;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && !lt) begin
      val_nxt = prev_lt ? ctl.value : prev_val;
    end else if ((ctl.rmv && !lt) || ctl.pop) begin
      val_nxt = next_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ----- hw/rtl/sle_report.sv -----
// Result stage: reads the ends of the row and holds the result item for the output channel.
module sle_report
  import sle_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] cell_val [CAPACITY],
  input  logic [CNT_W-1:0]         count_r,
  input  logic                     pend_r,
  input  logic                     ok_r,
  output logic                     load,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output logic [71:0]              out_tdata
);

  logic                     valid_r;
  logic                     ok_out_r;
  logic signed [DATA_W-1:0] lo_r;
  logic signed [DATA_W-1:0] hi_r;
  logic [OUT_CNT_W-1:0]     cnt_out_r;
  logic signed [DATA_W-1:0] lo_sel;
  logic signed [DATA_W-1:0] hi_sel;

  assign load = pend_r && (!valid_r || out_tready);

  always_comb begin
    lo_sel = (count_r != '0) ? cell_val[0] : '0;
    hi_sel = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (count_r == CNT_W'(i + 1)) begin
        hi_sel = hi_sel | cell_val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok_out_r  <= ok_r;
      lo_r      <= lo_sel;
      hi_r      <= hi_sel;
      cnt_out_r <= OUT_CNT_W'(count_r);
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {cnt_out_r, hi_r, lo_r, ok_out_r};

endmodule

// ----- hw/rtl/sorted_list_engine_top.sv -----
// Sorted list engine: a row of cells kept in ascending order, one operation per item.
// An accepted item is applied to the row at the accepting edge; its result item is
// registered once the result stage is free and is shown on out_tvalid from then on.
// Throughput: one item per cycle while the output side keeps taking results; every
// cell compares and shifts in parallel, so no operation iterates over the row.
// Reset: rst_n (synchronous, active low) empties the list and the result stage at once.
module sorted_list_engine_top
  import sle_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [31:0] value
  input  logic [2:0]  in_tuser,    // [2:0] func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata    // [0] done_ok, [32:1] smallest, [64:33] largest, [71:65] count
);

  logic                     accept;
  logic                     load;
  logic                     pend_r;
  logic                     ok_r;
  logic                     ok_nxt;
  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     full;
  logic                     empty;
  logic                     found;
  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [CAPACITY-1:0]      cell_hit;
  logic [CAPACITY-1:0]      cell_occ;

  assign accept = in_tvalid && in_tready;
  assign in_tready = !pend_r || load;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign empty  = (count_r == '0);
  assign found  = |cell_hit;

  always_comb begin
    ctl       = '0;
    ctl.value = $signed(in_tdata);
    ok_nxt    = 1'b0;
    count_nxt = count_r;
    unique case (in_tuser)
      FN_INSERT: begin
        ctl.ins   = accept && !full;
        ok_nxt    = !full;
        count_nxt = full ? count_r : count_r + CNT_W'(1);
      end
      FN_REMOVE_VAL: begin
        ctl.rmv   = accept && found;
        ok_nxt    = found;
        count_nxt = found ? count_r - CNT_W'(1) : count_r;
      end
      FN_REMOVE_MIN: begin
        ctl.pop   = accept && !empty;
        ok_nxt    = !empty;
        count_nxt = empty ? count_r : count_r - CNT_W'(1);
      end
      FN_REMOVE_MAX: begin
        ok_nxt    = !empty;
        count_nxt = empty ? count_r : count_r - CNT_W'(1);
      end
      FN_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      default: begin
        ok_nxt    = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                     p_lt;
    logic signed [DATA_W-1:0] p_val;
    logic signed [DATA_W-1:0] n_val;

    assign cell_occ[i] = (CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign p_lt  = 1'b1;
      assign p_val = '0;
    end else begin : g_mid
      assign p_lt  = cell_lt[i-1];
      assign p_val = cell_val[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign n_val = cell_val[i];
    end else begin : g_body
      assign n_val = cell_val[i+1];
    end

    sle_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .occ      (cell_occ[i]),
      .prev_lt  (p_lt),
      .prev_val (p_val),
      .next_val (n_val),
      .val_r    (cell_val[i]),
      .lt       (cell_lt[i]),
      .hit      (cell_hit[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
        ok_r    <= ok_nxt;
        pend_r  <= 1'b1;
      end else if (load) begin
        pend_r  <= 1'b0;
      end
    end
  end

  sle_report u_report (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_val   (cell_val),
    .count_r    (count_r),
    .pend_r     (pend_r),
    .ok_r       (ok_r),
    .load       (load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_reject: assert property (@(posedge clk) disable iff (!rst_n)
    accept && full && (in_tuser == FN_INSERT) |=> !ok_r && (count_r == CNT_W'(CAPACITY)))
    else $error("insert into full list took effect");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_tuser == FN_CLEAR) |=> (count_r == '0) && ok_r)
    else $error("clear did not empty the list");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && out_tvalid && !out_tready |-> !in_tready)
    else $error("item accepted while its predecessor's result is blocked");

  a_single_shift: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.ins, ctl.rmv, ctl.pop}))
    else $error("more than one shift mode driven into the row");

endmodule
